// ===== design/ppd_pkg.sv =====
// Package for the palette pixel phosphor decay block: item types, register
// indexes, queue sizes and the 6-to-8 bit color widening function.
// Depends on nothing; the top, front and back refer to it by scoped names.
package ppd_pkg;

    // Register indexes on the configuration port
    localparam logic REG_EFFECT_ON = 1'b0;
    localparam logic REG_DECAY     = 1'b1;

    // Reset value of the decay factor
    localparam logic [7:0] DECAY_RESET = 8'd214;

    // Queue sizes between front and back, and on the result side
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Kind of an accepted item
    typedef enum logic {
        KIND_PIXEL     = 1'b0,
        KIND_PAL_WRITE = 1'b1
    } t_kind;

    // Colors: index 2 is red, 1 is green, 0 is blue
    typedef logic [2:0][5:0] t_rgb6;
    typedef logic [2:0][7:0] t_rgb8;

    // Classified item passed from the front to the back
    typedef struct packed {
        t_kind       kind;
        logic        glow;   // pixel that reads and updates its accumulator
        logic [15:0] pos;
        logic [7:0]  idx;
        t_rgb6       rgb;
    } t_cmd;

    // Widen a 6-bit component by replicating its top bits
    function automatic logic [7:0] widen6(logic [5:0] c);
        return {c, c[5:4]};
    endfunction

endpackage

// ===== design/palette_pixel_phosphor_decay_top.sv =====
// Top level of the palette pixel phosphor decay block: configuration
// registers, front end, command queue, back end and result queue.
// Depends on ppd_pkg, ppd_front, ppd_fifo, ppd_back and ppd_ram.

// Converts 8-bit palette indices to 24-bit color at one item per clock while
// full is low. Items (palette writes and pixels) go in through push/full and
// results come out through empty/pop, one per pixel; palette writes give none.
// After reset the block holds full high while it zeroes the accumulator store
// one entry per cycle; configuration writes are taken during that time. A
// pixel passes the input register, command queue, palette/accumulator RAM read
// with the decay multiply, then max and write-back into the result queue. The
// accumulator RAM is read and written in the same cycle for different pixels,
// and back-to-back pixels at one position are served by forwarding, so the
// rate stays at one item per cycle while the result queue has room.
// The configuration may be written only while no item is in flight.
module palette_pixel_phosphor_decay_top #(
    parameter int FRAME_PIXELS = 64000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic        i_mode,
    input  logic [15:0] i_pixel_position,
    input  logic [7:0]  i_color_index,
    input  logic [5:0]  i_pal_red,
    input  logic [5:0]  i_pal_green,
    input  logic [5:0]  i_pal_blue,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue
);

    logic       r_effect_on;
    logic [7:0] r_decay;

    logic                          w_accept;
    logic                          w_front_ready;
    logic                          w_q_push;
    ppd_pkg::t_cmd                 w_front_cmd;
    logic                          w_q_full;
    logic                          w_q_empty;
    logic                          w_q_pop;
    ppd_pkg::t_cmd                 w_q_cmd;
    logic [$clog2(ppd_pkg::CMD_DEPTH + 1)-1:0] w_cmd_count;
    logic                          w_out_push;
    ppd_pkg::t_rgb8                w_out_rgb;
    logic                          w_out_full;
    logic [ppd_pkg::OUT_CNT_W-1:0] w_out_count;
    ppd_pkg::t_rgb8                w_out_data;
    logic                          w_clearing;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effect_on <= 1'b0;
            r_decay     <= ppd_pkg::DECAY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ppd_pkg::REG_EFFECT_ON: r_effect_on <= i_cfg_data[0];
                ppd_pkg::REG_DECAY:     r_decay     <= i_cfg_data;
                default:                r_decay     <= r_decay;
            endcase
        end
    end

    // Refuse items during the clearing pass or when the front is stuck
    assign full     = w_clearing || !w_front_ready;
    assign w_accept = push && !full;

    ppd_front #(
        .FRAME_PIXELS (FRAME_PIXELS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_effect_on      (r_effect_on),
        .i_mode           (i_mode),
        .i_pixel_position (i_pixel_position),
        .i_color_index    (i_color_index),
        .i_pal_red        (i_pal_red),
        .i_pal_green      (i_pal_green),
        .i_pal_blue       (i_pal_blue),
        .o_ready          (w_front_ready),
        .i_q_full         (w_q_full),
        .o_q_push         (w_q_push),
        .o_q_cmd          (w_front_cmd)
    );

    ppd_fifo #(
        .WIDTH ($bits(ppd_pkg::t_cmd)),
        .DEPTH (ppd_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_front_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_cmd),
        .o_empty (w_q_empty),
        .o_count (w_cmd_count)
    );

    ppd_back #(
        .FRAME_PIXELS (FRAME_PIXELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_decay     (r_decay),
        .i_q_empty   (w_q_empty),
        .i_q_cmd     (w_q_cmd),
        .o_q_pop     (w_q_pop),
        .i_out_count (w_out_count),
        .o_out_push  (w_out_push),
        .o_out_rgb   (w_out_rgb),
        .o_clearing  (w_clearing)
    );

    ppd_fifo #(
        .WIDTH (24),
        .DEPTH (ppd_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_rgb),
        .o_full  (w_out_full),
        .i_pop   (pop && !empty),
        .o_data  (w_out_data),
        .o_empty (empty),
        .o_count (w_out_count)
    );

    assign o_red   = w_out_data[2];
    assign o_green = w_out_data[1];
    assign o_blue  = w_out_data[0];

    // The output credit check must keep the result queue from overflowing
    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_push |-> (!w_out_full || (pop && !empty)))
        else $error("result pushed into a full result queue");

    // The front must never push into a full command queue
    a_cmd_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_full)
        else $error("command pushed into a full command queue");

    // The command queue never holds more than its depth
    a_cmd_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_count <= ppd_pkg::CMD_DEPTH)
        else $error("command queue count beyond its depth");

    // The clearing pass starts right after reset and blocks input
    a_clear_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> full && empty)
        else $error("block not clearing after reset");

    // No pop from the command queue and no result push during the clearing pass
    a_no_issue_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !w_q_pop && !w_out_push)
        else $error("item issued during the clearing pass");

endmodule

// ===== design/ppd_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// A read at the address being written returns the old data. Uses no package.
module ppd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read the array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/ppd_fifo.sv =====
// Small register-based queue with a fill count, used between front and back
// and on the result side. Uses no package.
module ppd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic [CW-1:0]    o_count
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    n_wr;
    logic [AW-1:0]    n_rd;
    logic [CW-1:0]    n_count;

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    // Hold pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            r_count <= n_count;
        end
    end

    // Store pushed data
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

// ===== design/ppd_front.sv =====
// Front end: registers an accepted item, classifies it as palette write or
// pixel, flags pixels that use the accumulator, and feeds the command queue.
// Depends on ppd_pkg.
module ppd_front #(
    parameter int FRAME_PIXELS = 64000
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_effect_on,
    input  logic          i_mode,
    input  logic [15:0]   i_pixel_position,
    input  logic [7:0]    i_color_index,
    input  logic [5:0]    i_pal_red,
    input  logic [5:0]    i_pal_green,
    input  logic [5:0]    i_pal_blue,
    output logic          o_ready,
    input  logic          i_q_full,
    output logic          o_q_push,
    output ppd_pkg::t_cmd o_q_cmd
);

    logic          r_valid;
    ppd_pkg::t_cmd r_cmd;
    ppd_pkg::t_cmd n_cmd;
    logic          w_inside;

    // Classify the incoming item
    always_comb begin
        w_inside   = (32'(i_pixel_position) < 32'(FRAME_PIXELS));
        n_cmd.kind = ppd_pkg::t_kind'(i_mode);
        n_cmd.glow = (n_cmd.kind == ppd_pkg::KIND_PIXEL) && i_effect_on && w_inside;
        n_cmd.pos  = i_pixel_position;
        n_cmd.idx  = i_color_index;
        n_cmd.rgb  = {i_pal_red, i_pal_green, i_pal_blue};
    end

    assign o_q_push = r_valid && !i_q_full;
    assign o_ready  = !r_valid || !i_q_full;
    assign o_q_cmd  = r_cmd;

    // Hold the item until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== design/ppd_back.sv =====
// Back end: palette store, accumulator store with its clearing pass, the
// three-stage lookup / decay / max pipeline with write-back forwarding.
// Depends on ppd_pkg and ppd_ram.
module ppd_back #(
    parameter int FRAME_PIXELS = 64000,
    localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [7:0]                     i_decay,
    input  logic                           i_q_empty,
    input  ppd_pkg::t_cmd                  i_q_cmd,
    output logic                           o_q_pop,
    input  logic [ppd_pkg::OUT_CNT_W-1:0]  i_out_count,
    output logic                           o_out_push,
    output ppd_pkg::t_rgb8                 o_out_rgb,
    output logic                           o_clearing
);

    // Clearing pass over the accumulator store
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    // Stage B: RAM data returns
    logic          r_b_valid;
    logic          r_b_glow;
    logic [15:0]   r_b_pos;

    // Stage C: decayed value and palette color ready
    logic           r_c_valid;
    logic           r_c_glow;
    logic [15:0]    r_c_pos;
    ppd_pkg::t_rgb8 r_c_col;
    ppd_pkg::t_rgb8 r_c_dec;

    // Last accumulator write, for reads that raced it
    logic           r_d_valid;
    logic [15:0]    r_d_pos;
    ppd_pkg::t_rgb8 r_d_val;

    logic           w_issue;
    logic           w_is_pixel;
    ppd_pkg::t_rgb6 w_pal_rdata;
    logic [23:0]    w_glow_rdata;
    ppd_pkg::t_rgb8 w_col;
    ppd_pkg::t_rgb8 w_acc;
    ppd_pkg::t_rgb8 n_dec;
    ppd_pkg::t_rgb8 w_c_res;
    logic           w_c_wr;
    logic           w_glow_we;
    logic [AW-1:0]  w_glow_waddr;
    logic [23:0]    w_glow_wdata;
    logic [15:0]    w_prod [3];

    // Issue the queue head outside the clearing pass when results have room in the output queue
    assign w_is_pixel = (i_q_cmd.kind == ppd_pkg::KIND_PIXEL);
    assign w_issue    = !r_clearing && !i_q_empty
                     && (int'(i_out_count) + int'(r_b_valid) + int'(r_c_valid)
                         < ppd_pkg::OUT_DEPTH);
    assign o_q_pop    = w_issue;

    ppd_ram #(
        .WIDTH (18),
        .DEPTH (256)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_issue && !w_is_pixel),
        .i_waddr (i_q_cmd.idx),
        .i_wdata (i_q_cmd.rgb),
        .i_re    (w_issue && w_is_pixel),
        .i_raddr (i_q_cmd.idx),
        .o_rdata (w_pal_rdata)
    );

    // Clear, or write back the raised accumulator
    assign w_c_wr       = r_c_valid && r_c_glow;
    assign w_glow_we    = r_clearing || w_c_wr;
    assign w_glow_waddr = r_clearing ? r_clr_addr : AW'(r_c_pos);
    assign w_glow_wdata = r_clearing ? 24'd0 : w_c_res;

    ppd_ram #(
        .WIDTH (24),
        .DEPTH (FRAME_PIXELS)
    ) u_glow (
        .i_clk   (i_clk),
        .i_we    (w_glow_we),
        .i_waddr (w_glow_waddr),
        .i_wdata (w_glow_wdata),
        .i_re    (w_issue && w_is_pixel && i_q_cmd.glow),
        .i_raddr (AW'(i_q_cmd.pos)),
        .o_rdata (w_glow_rdata)
    );

    // Stage C result: palette color, raised to the decayed value when the effect applies
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_c_res[k] = (r_c_glow && (r_c_dec[k] > r_c_col[k])) ? r_c_dec[k] : r_c_col[k];
        end
    end

    // Stage B: widen color, forward pending writes, decay
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_col[k] = ppd_pkg::widen6(w_pal_rdata[k]);
        end
        if (w_c_wr && (r_c_pos == r_b_pos)) begin
            w_acc = w_c_res;
        end else if (r_d_valid && (r_d_pos == r_b_pos)) begin
            w_acc = r_d_val;
        end else begin
            w_acc = w_glow_rdata;
        end
        for (int k = 0; k < 3; k++) begin
            w_prod[k] = w_acc[k] * i_decay;
            n_dec[k]  = w_prod[k][15:8];
        end
    end

    // Hold control state of the clearing pass and the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_b_valid  <= 1'b0;
            r_c_valid  <= 1'b0;
            r_d_valid  <= 1'b0;
        end else begin
            if (r_clearing) begin
                if (r_clr_addr == AW'(FRAME_PIXELS - 1)) begin
                    r_clearing <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            r_b_valid <= w_issue && w_is_pixel;
            r_c_valid <= r_b_valid;
            if (w_c_wr) begin
                r_d_valid <= 1'b1;
            end
        end
    end

    // Advance payload through the stages
    always_ff @(posedge i_clk) begin
        r_b_glow <= i_q_cmd.glow;
        r_b_pos  <= i_q_cmd.pos;
        r_c_glow <= r_b_glow;
        r_c_pos  <= r_b_pos;
        r_c_col  <= w_col;
        r_c_dec  <= n_dec;
        if (w_c_wr) begin
            r_d_pos <= r_c_pos;
            r_d_val <= w_c_res;
        end
    end

    assign o_out_push = r_c_valid;
    assign o_out_rgb  = w_c_res;
    assign o_clearing = r_clearing;

endmodule

// ===== sim/tb_palette_pixel_phosphor_decay_top.sv =====
// Testbench for palette_pixel_phosphor_decay_top: a queue-fed driver, a receiver
// with random and long stalls, and a predictor of palette colors and pixel glow.
// Depends on ppd_pkg and the design files under design/.
`timescale 1ns / 1ps

module tb_palette_pixel_phosphor_decay_top;

    localparam int FRAME_PIXELS = 64000;
    localparam int IDLE_PCT     = 31;
    localparam int SETTLE       = 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 125;

    typedef struct {
        ppd_pkg::t_kind kind;
        logic [15:0]    pos;
        logic [7:0]     idx;
        logic [5:0]     red;
        logic [5:0]     green;
        logic [5:0]     blue;
    } t_pixel_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = ppd_pkg::REG_EFFECT_ON;
    logic [7:0]  i_cfg_data = 8'd0;
    logic        push = 1'b0;
    logic        full;
    logic        i_mode = ppd_pkg::KIND_PIXEL;
    logic [15:0] i_pixel_position = 16'd0;
    logic [7:0]  i_color_index = 8'd0;
    logic [5:0]  i_pal_red = 6'd0;
    logic [5:0]  i_pal_green = 6'd0;
    logic [5:0]  i_pal_blue = 6'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;

    // Predictor state and the configuration it follows
    bit [2:0][5:0]         pal_mem [256];
    bit [2:0][7:0]         glow_mem [FRAME_PIXELS];
    logic                  glow_on = 1'b0;
    logic [7:0]            decay_factor = ppd_pkg::DECAY_RESET;
    ppd_pkg::t_rgb8        expected_colors [$];

    // Stimulus bookkeeping
    t_pixel_item           pending_items [$];
    bit                    pal_known [256];
    logic [7:0]            known_idx [$];
    logic                  in_taken = 1'b0;
    bit                    no_idle = 1'b0;
    bit                    hold_req = 1'b0;
    bit                    hold_done = 1'b0;
    int                    hold_left = 0;
    int                    error_count = 0;

    palette_pixel_phosphor_decay_top #(
        .FRAME_PIXELS(FRAME_PIXELS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .push(push),
        .full(full),
        .i_mode(i_mode),
        .i_pixel_position(i_pixel_position),
        .i_color_index(i_color_index),
        .i_pal_red(i_pal_red),
        .i_pal_green(i_pal_green),
        .i_pal_blue(i_pal_blue),
        .empty(empty),
        .pop(pop),
        .o_red(o_red),
        .o_green(o_green),
        .o_blue(o_blue)
    );

    // Clock: 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Look up, widen and apply glow for one pixel; update the glow store
    function automatic ppd_pkg::t_rgb8 predict_pixel(logic [15:0] pos, logic [7:0] idx);
        ppd_pkg::t_rgb8 color;
        logic [15:0]    faded;
        logic [7:0]     lit;
        logic [5:0]     comp;
        logic           in_frame;
        in_frame = pos < FRAME_PIXELS;
        for (int k = 0; k < 3; k++) begin
            comp = pal_mem[idx][k];
            lit = {comp, 2'b00} | {6'd0, comp[5:4]};
            if (glow_on) begin
                faded = (in_frame ? {8'd0, glow_mem[pos][k]} : 16'd0) * {8'd0, decay_factor};
                if (faded[15:8] > lit) begin
                    lit = faded[15:8];
                end
                if (in_frame) begin
                    glow_mem[pos][k] = lit;
                end
            end
            color[k] = lit;
        end
        return color;
    endfunction

    function automatic void add_palette(logic [7:0] idx, logic [5:0] r, logic [5:0] g,
                                        logic [5:0] b);
        t_pixel_item it;
        it.kind  = ppd_pkg::KIND_PAL_WRITE;
        it.pos   = 16'($urandom_range(0, 65535));
        it.idx   = idx;
        it.red   = r;
        it.green = g;
        it.blue  = b;
        pending_items.push_back(it);
        if (!pal_known[idx]) begin
            pal_known[idx] = 1'b1;
            known_idx.push_back(idx);
        end
    endfunction

    function automatic void add_pixel(logic [15:0] pos, logic [7:0] idx);
        t_pixel_item it;
        it.kind  = ppd_pkg::KIND_PIXEL;
        it.pos   = pos;
        it.idx   = idx;
        it.red   = 6'($urandom_range(0, 63));
        it.green = 6'($urandom_range(0, 63));
        it.blue  = 6'($urandom_range(0, 63));
        pending_items.push_back(it);
    endfunction

    // Mostly pixels on a few hot positions so the glow builds up and decays
    function automatic void queue_random(int n);
        int          sel;
        logic [15:0] pos;
        for (int i = 0; i < n; i++) begin
            if (known_idx.size() == 0 || $urandom_range(0, 99) < 25) begin
                add_palette(8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                            6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 55) begin
                    pos = 16'($urandom_range(0, 15));
                end else if (sel < 65) begin
                    pos = 16'($urandom_range(FRAME_PIXELS, 65535));
                end else if (sel < 72) begin
                    pos = 16'(FRAME_PIXELS - 1 - $urandom_range(0, 3));
                end else begin
                    pos = 16'($urandom_range(0, FRAME_PIXELS - 1));
                end
                add_pixel(pos, known_idx[$urandom_range(0, known_idx.size() - 1)]);
            end
        end
    endfunction

    task automatic write_reg(logic index, logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Wait until every item is in and every result is out, then let the pipe settle
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_items.size() != 0 || push || expected_colors.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Driver: offer the next pending item, hold it until accepted
    always @(negedge i_clk) begin : drive_items
        t_pixel_item it;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && !in_taken) begin
            // hold the current item
        end else if (pending_items.size() != 0 &&
                     (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
            it = pending_items.pop_front();
            i_mode           <= it.kind;
            i_pixel_position <= it.pos;
            i_color_index    <= it.idx;
            i_pal_red        <= it.red;
            i_pal_green      <= it.green;
            i_pal_blue       <= it.blue;
            push             <= 1'b1;
        end else begin
            push <= 1'b0;
        end
    end

    // Receiver: random stalls plus one long hold-off counted here
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Monitor: track config, predict accepted items, check popped results
    always @(posedge i_clk) begin : check_results
        ppd_pkg::t_rgb8 want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= push && !full;
            if (i_cfg_we) begin
                if (i_cfg_index == ppd_pkg::REG_EFFECT_ON) begin
                    glow_on = i_cfg_data[0];
                end else begin
                    decay_factor = i_cfg_data;
                end
            end
            if (push && !full) begin
                if (i_mode == ppd_pkg::KIND_PAL_WRITE) begin
                    pal_mem[i_color_index] = {i_pal_red, i_pal_green, i_pal_blue};
                end else begin
                    expected_colors.push_back(predict_pixel(i_pixel_position, i_color_index));
                end
            end
            if (pop && !empty) begin
                if (expected_colors.size() == 0) begin
                    report_mismatch($sformatf("result %0d/%0d/%0d with nothing expected",
                                              o_red, o_green, o_blue));
                end else begin
                    want = expected_colors.pop_front();
                    if (o_red !== want[2]) begin
                        report_mismatch($sformatf("red got %0d expected %0d", o_red, want[2]));
                    end
                    if (o_green !== want[1]) begin
                        report_mismatch($sformatf("green got %0d expected %0d",
                                                  o_green, want[1]));
                    end
                    if (o_blue !== want[0]) begin
                        report_mismatch($sformatf("blue got %0d expected %0d",
                                                  o_blue, want[0]));
                    end
                end
            end
        end
    end

    // Stimulus: directed items, then random phases under several settings
    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Pass-through with reset settings
        @(posedge i_clk);
        add_palette(8'd0, 6'd0, 6'd0, 6'd0);
        add_palette(8'd255, 6'd63, 6'd63, 6'd63);
        add_palette(8'h5A, 6'd21, 6'd42, 6'd1);
        add_pixel(16'd0, 8'd255);
        add_pixel(16'd65535, 8'h5A);
        wait_drained();

        // Glow on: decay at one spot, frame edge, beyond frame, palette rewrite
        write_reg(ppd_pkg::REG_EFFECT_ON, 8'd1);
        @(posedge i_clk);
        add_pixel(16'd0, 8'd255);
        add_pixel(16'd0, 8'd0);
        add_pixel(16'd0, 8'd0);
        add_pixel(16'(FRAME_PIXELS - 1), 8'h5A);
        add_pixel(16'(FRAME_PIXELS), 8'd255);
        add_pixel(16'd65535, 8'd0);
        add_palette(8'd0, 6'd63, 6'd0, 6'd32);
        add_pixel(16'd0, 8'd0);
        add_pixel(16'd0, 8'd0);
        add_pixel(16'(FRAME_PIXELS - 1), 8'd0);
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(ppd_pkg::REG_EFFECT_ON, 8'd1);
                    write_reg(ppd_pkg::REG_DECAY, 8'd255);
                end
                1: write_reg(ppd_pkg::REG_DECAY, 8'd0);
                2: write_reg(ppd_pkg::REG_DECAY, ppd_pkg::DECAY_RESET);
                3: write_reg(ppd_pkg::REG_DECAY, 8'($urandom_range(0, 255)));
                4: begin
                    write_reg(ppd_pkg::REG_EFFECT_ON, 8'd0);
                    write_reg(ppd_pkg::REG_DECAY, 8'($urandom_range(0, 255)));
                end
                default: begin
                    write_reg(ppd_pkg::REG_EFFECT_ON, 8'd1);
                    write_reg(ppd_pkg::REG_DECAY, 8'd1);
                end
            endcase
            @(posedge i_clk);
            no_idle = (phase == 2);
            queue_random(PHASE_ITEMS);
            // back up the result side so the block fills and stalls its input
            if (phase == 3) begin
                hold_req = 1'b1;
            end
            wait_drained();
        end

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Timeout covers the clearing pass after reset with ample margin
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
